// File: rtl/egsm_pkg.sv
`default_nettype none
package egsm_pkg;

    localparam int OP_W      = 2;
    localparam int NODE_W    = 16;
    localparam int XVAL_W    = 24;
    localparam int ACC_W     = 48;
    localparam int NPE_W     = 6;
    localparam int SUM_W     = 30;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 64;

    localparam int MUL_A_W   = 24;
    localparam int MUL_B_W   = 31;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    localparam int NODES_DEFAULT   = 65536;
    localparam int MAX_NPE_DEFAULT = 32;
    localparam logic [NPE_W-1:0] NPE_RESET = 6'd4;
    localparam logic [NPE_W-1:0] NPE_MIN   = 6'd2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_GATHER = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [NODE_W-1:0] slot;
        logic [XVAL_W-1:0] val;
    } gbuf_entry_t;

endpackage
`default_nettype wire

// File: rtl/egsm_mul.sv
`default_nettype none
module egsm_mul (
    input  wire logic                          aclk,
    input  wire logic [egsm_pkg::MUL_A_W-1:0]  a,
    input  wire logic [egsm_pkg::MUL_B_W-1:0]  b,
    output logic      [egsm_pkg::MUL_P_W-1:0]  prod
);
    import egsm_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;
    logic [MUL_P_W-1:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// File: rtl/egsm_gbuf.sv
`default_nettype none
module egsm_gbuf #(
    parameter int DEPTH = egsm_pkg::MAX_NPE_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [IW-1:0]              wr_addr,
    input  wire egsm_pkg::gbuf_entry_t      wr_data,
    input  wire logic                       rd_en,
    input  wire logic [IW-1:0]              rd_addr,
    output egsm_pkg::gbuf_entry_t           rd_data
);
    import egsm_pkg::*;

    gbuf_entry_t mem [DEPTH];
    gbuf_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/element_gather_scatter_matvec_unit.sv
`default_nettype none
// Matrix-free element matvec with a graph-Laplacian local matrix. Each input
// transaction carries an op in s_tuser: load stores x[node] (unsigned Q0.24)
// and clears y[node], gather adds one node to the current element, read
// returns y[node] (signed Q24.24, saturated) on the m_ side. Once
// nodes_per_element nodes are gathered, every gathered node in order gets
// y += npe*x_i - sum(x). Node indices map to storage modulo NODES through a
// reciprocal multiply on one shared multiplier, which also scales x_i, so
// every transaction passes through accept plus three sequencer steps,
// gather and read one more, a read also waits for the output register to
// free, and a completing gather adds a read, a multiply and an add step per
// node of the element for the read-modify-write of y. The block takes
// no new transaction until the current one is done. x and y entries never
// loaded read back undefined. A nodes_per_element write drops any partly
// gathered element; write it only while the block is idle.
module element_gather_scatter_matvec_unit #(
    parameter int NODES                 = egsm_pkg::NODES_DEFAULT,
    parameter int MAX_NODES_PER_ELEMENT = egsm_pkg::MAX_NPE_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // node [15:0], node_value [39:16]
    input  wire logic [egsm_pkg::S_DATA_W-1:0]   s_tdata,
    // op [1:0]
    input  wire logic [egsm_pkg::OP_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // node_res [15:0], accumulated [63:16]
    output logic      [egsm_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [egsm_pkg::NPE_W-1:0]      cfg_wdata
);
    import egsm_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int IW = $clog2(MAX_NODES_PER_ELEMENT);
    localparam int CW = $clog2(MAX_NODES_PER_ELEMENT + 1);
    localparam longint unsigned RECIP =
        (64'd4294967296 + 64'(NODES) - 64'd1) / 64'(NODES);
    localparam logic [NPE_W-1:0] NPE_MAX = NPE_W'(MAX_NODES_PER_ELEMENT);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MQ     = 9'b000000010,
        ST_MN     = 9'b000000100,
        ST_MS     = 9'b000001000,
        ST_GS     = 9'b000010000,
        ST_RD     = 9'b000100000,
        ST_SC_RD  = 9'b001000000,
        ST_SC_MUL = 9'b010000000,
        ST_SC_ADD = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    op_t               op_reg, op_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [XVAL_W-1:0] value_reg, value_next;
    logic [NODE_W-1:0] slot_reg, slot_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [NPE_W-1:0]  npe_reg, npe_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [NODE_W-1:0] m_node_reg;
    logic [ACC_W-1:0]  m_acc_reg;
    logic              out_load;

    logic [XVAL_W-1:0] x_mem [NODES];
    logic [ACC_W-1:0]  y_mem [NODES];
    logic [XVAL_W-1:0] x_q_reg;
    logic [ACC_W-1:0]  y_q_reg;

    logic              x_we;
    logic [AW-1:0]     x_addr;
    logic              y_we;
    logic [AW-1:0]     y_waddr;
    logic [AW-1:0]     y_raddr;
    logic [ACC_W-1:0]  y_wdata;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;

    logic              gb_we;
    gbuf_entry_t       gb_wdata;
    logic              gb_re;
    gbuf_entry_t       gb_rdata;

    logic [NPE_W-1:0]  npe_eff;
    logic [CW-1:0]     npe_cnt;
    logic [CW-1:0]     count_inc;
    logic [CW-1:0]     idx_inc;
    logic [NODE_W-1:0] slot_c;

    logic signed [31:0]      contrib;
    logic signed [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0]        acc_sat;

    egsm_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    egsm_gbuf #(
        .DEPTH (MAX_NODES_PER_ELEMENT),
        .IW    (IW)
    ) u_gbuf (
        .aclk    (aclk),
        .wr_en   (gb_we),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (gb_wdata),
        .rd_en   (gb_re),
        .rd_addr (idx_reg),
        .rd_data (gb_rdata)
    );

    always_comb begin
        if (npe_reg < NPE_MIN) begin
            npe_eff = NPE_MIN;
        end else if (npe_reg > NPE_MAX) begin
            npe_eff = NPE_MAX;
        end else begin
            npe_eff = npe_reg;
        end
    end

    assign npe_cnt   = CW'(npe_eff);
    assign count_inc = count_reg + CW'(1);
    assign idx_inc   = CW'(idx_reg) + CW'(1);
    assign slot_c    = node_reg - mul_prod[NODE_W-1:0];

    // shared multiplier: node*recip, quotient*NODES, npe*x
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (1'b1)
            state_reg[0], state_reg[3], state_reg[4], state_reg[5],
            state_reg[6], state_reg[8]: begin
                mul_a = '0;
                mul_b = '0;
            end
            state_reg[1]: begin
                mul_a = MUL_A_W'(node_reg);
                mul_b = MUL_B_W'(RECIP);
            end
            state_reg[2]: begin
                mul_a = MUL_A_W'(mul_prod[47:32]);
                mul_b = MUL_B_W'(NODES);
            end
            state_reg[7]: begin
                mul_a = gb_rdata.val;
                mul_b = MUL_B_W'(npe_eff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign contrib = $signed({3'b000, mul_prod[28:0]}) - $signed({2'b00, sum_reg});
    assign acc_sum = $signed({y_q_reg[ACC_W-1], y_q_reg})
                   + $signed({{(ACC_W-31){contrib[31]}}, contrib});

    always_comb begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        x_we    = (state_reg == ST_MS) && (op_reg == OP_LOAD);
        x_addr  = AW'(slot_c);
        y_we    = x_we || (state_reg == ST_SC_ADD);
        y_waddr = (state_reg == ST_SC_ADD) ? AW'(gb_rdata.slot) : AW'(slot_c);
        y_wdata = (state_reg == ST_SC_ADD) ? acc_sat : '0;
        y_raddr = (state_reg == ST_SC_MUL) ? AW'(gb_rdata.slot) :
                  ((state_reg == ST_RD) ? AW'(slot_reg) : AW'(slot_c));
        gb_we   = (state_reg == ST_GS);
        gb_wdata.slot = slot_reg;
        gb_wdata.val  = x_q_reg;
        gb_re   = (state_reg == ST_SC_RD);
    end

    always_ff @(posedge aclk) begin
        if (x_we) begin
            x_mem[x_addr] <= value_reg;
        end
        x_q_reg <= x_mem[x_addr];
    end

    always_ff @(posedge aclk) begin
        if (y_we) begin
            y_mem[y_waddr] <= y_wdata;
        end
        y_q_reg <= y_mem[y_raddr];
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        node_next  = node_reg;
        value_next = value_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        idx_next   = idx_reg;
        npe_next   = npe_reg;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tuser);
                    node_next  = s_tdata[NODE_W-1:0];
                    value_next = s_tdata[NODE_W +: XVAL_W];
                    state_next = ST_MQ;
                end
            end
            ST_MQ: begin
                state_next = ST_MN;
            end
            ST_MN: begin
                state_next = ST_MS;
            end
            ST_MS: begin
                slot_next = slot_c;
                unique case (op_reg)
                    OP_GATHER: state_next = ST_GS;
                    OP_READ:   state_next = ST_RD;
                    OP_LOAD, OP_NONE: state_next = ST_IDLE;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_GS: begin
                sum_next = sum_reg + SUM_W'(x_q_reg);
                if (count_inc == npe_cnt) begin
                    idx_next   = '0;
                    state_next = ST_SC_RD;
                end else begin
                    count_next = count_inc;
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SC_RD: begin
                state_next = ST_SC_MUL;
            end
            ST_SC_MUL: begin
                state_next = ST_SC_ADD;
            end
            ST_SC_ADD: begin
                if (idx_inc == npe_cnt) begin
                    count_next = '0;
                    sum_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next   = IW'(idx_inc);
                    state_next = ST_SC_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            npe_next   = cfg_wdata;
            count_next = '0;
            sum_next   = '0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            sum_reg      <= '0;
            npe_reg      <= NPE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            npe_reg      <= npe_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        node_reg  <= node_next;
        value_reg <= value_next;
        slot_reg  <= slot_next;
        idx_reg   <= idx_next;
        if (out_load) begin
            m_node_reg <= node_reg;
            m_acc_reg  <= y_q_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_acc_reg, m_node_reg};

endmodule
`default_nettype wire

// File: verif/element_gather_scatter_matvec_unit_tb.sv
`default_nettype none
module element_gather_scatter_matvec_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import egsm_pkg::*;

    localparam int IDLE_PCT    = 15;
    localparam int SETTLE      = 200;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 250;
    localparam int WINDOW      = 24;

    typedef struct {
        op_t               op;
        logic [NODE_W-1:0] node;
        logic [XVAL_W-1:0] value;
    } node_txn_t;

    typedef struct {
        logic [NODE_W-1:0]        node;
        logic signed [ACC_W-1:0]  acc;
    } read_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we;
    logic [NPE_W-1:0]    cfg_wdata;

    element_gather_scatter_matvec_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // stimulus side
    node_txn_t          pending_items[$];
    logic [NODE_W-1:0]  live_nodes[$];
    bit                 is_live[logic [NODE_W-1:0]];
    bit                 took_item = 1'b0;
    bit                 steady = 1'b0;

    // predicted state of the block
    logic [XVAL_W-1:0]       node_x [0:NODES_DEFAULT-1];
    logic signed [ACC_W-1:0] node_y [0:NODES_DEFAULT-1];
    logic [NODE_W-1:0]       elem_nodes [0:MAX_NPE_DEFAULT-1];
    logic [XVAL_W-1:0]       elem_vals [0:MAX_NPE_DEFAULT-1];
    int unsigned             elem_fill = 0;
    logic [SUM_W-1:0]        elem_sum = '0;
    logic [NPE_W-1:0]        npe_reg = NPE_RESET;
    read_result_t            expected_reads[$];

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned n_loads = 0, n_gathers = 0, n_reads = 0, n_ignored = 0;
    int unsigned n_elements = 0, n_settings = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 20)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // prediction for one accepted transaction: load, gather with scatter-add, read
    task automatic predict_transaction(input op_t op, input logic [NODE_W-1:0] node,
                                       input logic [XVAL_W-1:0] value);
        int unsigned n;
        longint contrib;
        longint total;
        read_result_t res;
        case (op)
            OP_LOAD: begin
                node_x[node] = value;
                node_y[node] = '0;
                n_loads++;
            end
            OP_GATHER: begin
                n = (npe_reg < NPE_MIN) ? NPE_MIN :
                    ((npe_reg > MAX_NPE_DEFAULT) ? MAX_NPE_DEFAULT : npe_reg);
                if (elem_fill >= n) begin
                    elem_fill = 0;
                    elem_sum = '0;
                end
                elem_nodes[elem_fill] = node;
                elem_vals[elem_fill] = node_x[node];
                elem_sum = elem_sum + node_x[node];
                elem_fill++;
                if (elem_fill == n) begin
                    for (int i = 0; i < n; i++) begin
                        contrib = longint'(n) * longint'(elem_vals[i]) - longint'(elem_sum);
                        total = longint'(node_y[elem_nodes[i]]) + contrib;
                        if (total > longint'(ACC_MAX))
                            total = longint'(ACC_MAX);
                        else if (total < longint'(ACC_MIN))
                            total = longint'(ACC_MIN);
                        node_y[elem_nodes[i]] = total[ACC_W-1:0];
                    end
                    elem_fill = 0;
                    elem_sum = '0;
                    n_elements++;
                end
                n_gathers++;
            end
            OP_READ: begin
                res.node = node;
                res.acc = node_y[node];
                expected_reads.push_back(res);
                n_reads++;
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic queue_item(input op_t op, input logic [NODE_W-1:0] node,
                              input logic [XVAL_W-1:0] value);
        node_txn_t t;
        t.op = op;
        t.node = node;
        t.value = value;
        pending_items.push_back(t);
        if (op == OP_LOAD && !is_live.exists(node)) begin
            is_live[node] = 1'b1;
            live_nodes.push_back(node);
        end
    endtask

    function automatic logic [XVAL_W-1:0] random_x();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return XVAL_W'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // mostly recent nodes, so elements share nodes and accumulators build up
    function automatic logic [NODE_W-1:0] pick_live_node();
        int unsigned span;
        span = (live_nodes.size() < WINDOW) ? live_nodes.size() : WINDOW;
        if ($urandom_range(9) == 0)
            return live_nodes[$urandom_range(live_nodes.size() - 1)];
        return live_nodes[live_nodes.size() - 1 - $urandom_range(span - 1)];
    endfunction

    task automatic run_random_phase(input int unsigned count);
        int unsigned done;
        int unsigned r;
        done = 0;
        while (done < count) begin
            r = $urandom_range(99);
            if (r < 3) begin
                queue_item(OP_NONE, NODE_W'($urandom_range(0, 16'hFFFF)), random_x());
            end else begin
                if (r < 20) begin
                    if ($urandom_range(9) < 6)
                        queue_item(OP_LOAD, NODE_W'($urandom_range(0, 16'hFFFF)),
                                   random_x());
                    else
                        queue_item(OP_LOAD, pick_live_node(), random_x());
                end else if (r < 75) begin
                    queue_item(OP_GATHER, pick_live_node(), random_x());
                end else begin
                    queue_item(OP_READ, pick_live_node(), random_x());
                end
                done++;
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_reads.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_npe(input logic [NPE_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("element_gather_scatter_matvec_unit_tb failed");
            $finish;
        end
    end

    // input driver
    always @(negedge aclk) begin : feed
        node_txn_t nxt;
        if (aresetn && (!s_tvalid || took_item)) begin
            if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= nxt.op;
                s_tdata <= {nxt.value, nxt.node};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor: predicts on accepted inputs and checks accepted results
    always @(posedge aclk) begin : watch
        read_result_t want;
        took_item <= s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_we) begin
                npe_reg = cfg_wdata;
                elem_fill = 0;
                elem_sum = '0;
                n_settings++;
            end
            if (s_tvalid && s_tready)
                predict_transaction(op_t'(s_tuser), s_tdata[NODE_W-1:0],
                                    s_tdata[NODE_W +: XVAL_W]);
            if (m_tvalid && m_tready) begin
                if (expected_reads.size() == 0) begin
                    report_mismatch($sformatf("unexpected result transaction %h", m_tdata));
                end else begin
                    want = expected_reads.pop_front();
                    if (m_tdata[NODE_W-1:0] !== want.node)
                        report_mismatch($sformatf("node_res %h, expected %h",
                                                  m_tdata[NODE_W-1:0], want.node));
                    if (m_tdata[NODE_W +: ACC_W] !== want.acc)
                        report_mismatch($sformatf("accumulated for node %h: %h, expected %h",
                                                  want.node, m_tdata[NODE_W +: ACC_W], want.acc));
                end
            end
        end
    end

    initial begin
        logic [NPE_W-1:0] npe_plan[8];
        npe_plan = '{6'd2, 6'd32, 6'd63, 6'd0, 6'd7, 6'd1, 6'd33, 6'd16};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_NONE;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, reset value of nodes_per_element
        queue_item(OP_LOAD, 16'h0000, 24'hFFFFFF);
        queue_item(OP_LOAD, 16'hFFFF, 24'h000000);
        queue_item(OP_LOAD, 16'h5A5A, 24'h123456);
        queue_item(OP_LOAD, 16'hA5A5, 24'hABCDEF);
        queue_item(OP_READ, 16'h0000, 24'hFFFFFF);
        queue_item(OP_NONE, 16'hFFFF, 24'hFFFFFF);
        queue_item(OP_READ, 16'hFFFF, 24'h000000);
        // element with a repeated node
        queue_item(OP_GATHER, 16'h0000, 24'h000000);
        queue_item(OP_GATHER, 16'hFFFF, 24'h000000);
        queue_item(OP_GATHER, 16'h5A5A, 24'h000000);
        queue_item(OP_GATHER, 16'h0000, 24'h000000);
        queue_item(OP_READ, 16'h0000, 24'h000000);
        queue_item(OP_READ, 16'hFFFF, 24'h000000);
        queue_item(OP_READ, 16'h5A5A, 24'h000000);
        queue_item(OP_READ, 16'hA5A5, 24'h000000);
        queue_item(OP_GATHER, 16'hA5A5, 24'h000000);
        queue_item(OP_GATHER, 16'h0000, 24'h000000);
        queue_item(OP_GATHER, 16'h0000, 24'h000000);
        queue_item(OP_GATHER, 16'hA5A5, 24'h000000);
        queue_item(OP_READ, 16'h0000, 24'h000000);
        queue_item(OP_READ, 16'hA5A5, 24'h000000);
        // partial element, dropped by the next register write
        queue_item(OP_GATHER, 16'h5A5A, 24'h000000);
        queue_item(OP_GATHER, 16'hFFFF, 24'h000000);
        // reload clears the accumulator
        queue_item(OP_LOAD, 16'h0000, 24'h000001);
        queue_item(OP_READ, 16'h0000, 24'h000000);

        foreach (npe_plan[i]) begin
            write_npe(npe_plan[i]);
            steady = (i == 2);
            run_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (expected_reads.size() != 0)
            report_mismatch($sformatf("%0d reads never returned", expected_reads.size()));
        $display("covered %0d loads, %0d gathers in %0d completed elements, %0d reads, %0d ignored",
                 n_loads, n_gathers, n_elements, n_reads, n_ignored);
        $display("%0d nodes_per_element writes, %0d mismatches", n_settings, mismatch_count);
        if (mismatch_count == 0) begin
            $display("element_gather_scatter_matvec_unit_tb passed");
        end else begin
            $display("element_gather_scatter_matvec_unit_tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
